/* sv/fixed_partition_first_fit_core_defines.svh */
// Assertion helpers for the core's controller.
`ifndef FIXED_PARTITION_FIRST_FIT_CORE_DEFINES_SVH
`define FIXED_PARTITION_FIRST_FIT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FPFF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fpff_pkg.sv */
`timescale 1ns / 1ps

package fpff_pkg;

  // Table geometry
  localparam int MAX_PARTS = 16;
  localparam int PIDX_W    = 4;
  localparam int CNT_W     = 5;
  localparam int SIZE_W    = 16;
  localparam int OWNER_W   = 8;

  localparam logic [CNT_W-1:0] MAX_PARTS_CNT = CNT_W'(MAX_PARTS);

  // Command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming command
    logic step;       // advance the scan pointer
    logic do_single;  // finish a load, query or unused command
    logic do_grant;   // grant the entry under the scan pointer
    logic do_miss;    // report no fitting partition
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_alloc;   // latched command is an allocate
    logic scan_end;   // scan pointer has passed the partitions in use
    logic scan_hit;   // entry under the scan pointer is free and large enough
  } dp_stat_t;

endpackage

/* sv/fixed_partition_first_fit_core.sv */
`timescale 1ns / 1ps

// Channel   Transfer when        Signals
// input     start && !busy       command, partition_index, block_size, requester_id
// result    done                 status, granted_index, granted_size, taken, owner_id
// config    cfg_we               cfg_wdata (partition count)
//
// Load, query and unused commands pass once through the run state; done is registered.
// Allocate stays in the run state while the controller checks one partition per cycle,
// so the scan over the partitions in use sets the length.
// busy is high from the cycle after a transfer until the result shows; done lasts
// one cycle and the receiver cannot stall it. Synchronous reset clears the table.
module fixed_partition_first_fit_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [fpff_pkg::PIDX_W-1:0]   partition_index,
  input  logic [fpff_pkg::SIZE_W-1:0]   block_size,
  input  logic [fpff_pkg::OWNER_W-1:0]  requester_id,
  input  logic                          cfg_we,
  input  logic [fpff_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [fpff_pkg::PIDX_W-1:0]   granted_index,
  output logic [fpff_pkg::SIZE_W-1:0]   granted_size,
  output logic                          taken,
  output logic [fpff_pkg::OWNER_W-1:0]  owner_id
);
  import fpff_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequence each command
  fpff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (dp_stat),
    .cmd   (dp_cmd),
    .busy  (busy),
    .done  (done)
  );

  // Partition table, scan pointer and result registers
  fpff_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .command         (command),
    .partition_index (partition_index),
    .block_size      (block_size),
    .requester_id    (requester_id),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .status          (status),
    .granted_index   (granted_index),
    .granted_size    (granted_size),
    .taken           (taken),
    .owner_id        (owner_id)
  );

endmodule

/* sv/fpff_datapath.sv */
`timescale 1ns / 1ps

module fpff_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fpff_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic [1:0]                    command,
  input  logic [fpff_pkg::PIDX_W-1:0]   partition_index,
  input  logic [fpff_pkg::SIZE_W-1:0]   block_size,
  input  logic [fpff_pkg::OWNER_W-1:0]  requester_id,
  input  fpff_pkg::dp_cmd_t             cmd,
  output fpff_pkg::dp_stat_t            stat,
  output logic [1:0]                    status,
  output logic [fpff_pkg::PIDX_W-1:0]   granted_index,
  output logic [fpff_pkg::SIZE_W-1:0]   granted_size,
  output logic                          taken,
  output logic [fpff_pkg::OWNER_W-1:0]  owner_id
);
  import fpff_pkg::*;

  logic [CNT_W-1:0]   part_count;
  logic [CNT_W-1:0]   active_cnt;
  logic [1:0]         cmd_q;
  logic [PIDX_W-1:0]  idx_q;
  logic [SIZE_W-1:0]  req_q;
  logic [OWNER_W-1:0] who_q;
  logic [CNT_W-1:0]   ptr;

  logic [SIZE_W-1:0]  sizes  [MAX_PARTS];
  logic               flags  [MAX_PARTS];
  logic [OWNER_W-1:0] owners [MAX_PARTS];

  logic [PIDX_W-1:0]  rd_idx;
  logic [SIZE_W-1:0]  rd_size;
  logic               rd_flag;
  logic [OWNER_W-1:0] rd_owner;
  logic               idx_ok;
  logic               is_load;
  logic               is_query;

  // Hold the partition count register
  always_ff @(posedge clk) begin
    if (rst) begin
      part_count <= '0;
    end else if (cfg_we) begin
      part_count <= cfg_wdata;
    end
  end

  // Clamp the count to the table depth
  assign active_cnt = (part_count > MAX_PARTS_CNT) ? MAX_PARTS_CNT : part_count;

  // Latch the command and run the scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.capture) begin
      ptr <= '0;
    end else if (cmd.step) begin
      ptr <= ptr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= command;
      idx_q <= partition_index;
      req_q <= block_size;
      who_q <= requester_id;
    end
  end

  // Read the entry under the scan pointer or the addressed partition
  assign is_load  = (cmd_q == CMD_LOAD);
  assign is_query = (cmd_q == CMD_QUERY);
  assign rd_idx   = stat.is_alloc ? ptr[PIDX_W-1:0] : idx_q;
  assign rd_size  = sizes[rd_idx];
  assign rd_flag  = flags[rd_idx];
  assign rd_owner = owners[rd_idx];
  assign idx_ok   = ({1'b0, idx_q} < active_cnt);

  assign stat.is_alloc = (cmd_q == CMD_ALLOC);
  assign stat.scan_end = (ptr >= active_cnt);
  assign stat.scan_hit = !rd_flag && (rd_size >= req_q);

  // Update the partition table on load and grant
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PARTS; i++) begin
        sizes[i]  <= '0;
        flags[i]  <= 1'b0;
        owners[i] <= '0;
      end
    end else if (cmd.do_single && is_load && idx_ok) begin
      sizes[idx_q]  <= req_q;
      flags[idx_q]  <= 1'b0;
      owners[idx_q] <= '0;
    end else if (cmd.do_grant) begin
      flags[ptr[PIDX_W-1:0]]  <= 1'b1;
      owners[ptr[PIDX_W-1:0]] <= who_q;
    end
  end

  // Register the result fields
  always_ff @(posedge clk) begin
    if (cmd.do_single) begin
      if ((is_load || is_query) && idx_ok) begin
        status        <= ST_OK;
        granted_index <= idx_q;
        granted_size  <= is_load ? req_q : rd_size;
        taken         <= is_load ? 1'b0 : rd_flag;
        owner_id      <= is_load ? '0 : rd_owner;
      end else begin
        status        <= ST_RANGE;
        granted_index <= '0;
        granted_size  <= '0;
        taken         <= 1'b0;
        owner_id      <= '0;
      end
    end else if (cmd.do_grant) begin
      status        <= ST_OK;
      granted_index <= ptr[PIDX_W-1:0];
      granted_size  <= rd_size;
      taken         <= 1'b1;
      owner_id      <= who_q;
    end else if (cmd.do_miss) begin
      status        <= ST_NOFIT;
      granted_index <= '0;
      granted_size  <= '0;
      taken         <= 1'b0;
      owner_id      <= '0;
    end
  end

endmodule

/* sv/fpff_ctrl.sv */
`timescale 1ns / 1ps

module fpff_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fpff_pkg::dp_stat_t  stat,
  output fpff_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                done
);
  import fpff_pkg::*;
  `include "fixed_partition_first_fit_core_defines.svh"

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  // Decode the next state and the datapath commands
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_RUN;
        end
      end
      S_RUN: begin
        if (!stat.is_alloc) begin
          cmd.do_single = 1'b1;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else if (stat.scan_end) begin
          cmd.do_miss = 1'b1;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (stat.scan_hit) begin
          cmd.do_grant = 1'b1;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

  `FPFF_ASSERT_SAME(a_done_from_run, done, $past(state == S_RUN), "result without a command")
  `FPFF_ASSERT_NEXT(a_accept_runs, (state == S_IDLE) && start, state == S_RUN, "accept lost")
  `FPFF_ASSERT_SAME(a_one_finish, 1'b1, $onehot0({cmd.do_single, cmd.do_grant, cmd.do_miss}), "two finishes at once")
  `FPFF_ASSERT_SAME(a_step_in_range, cmd.step, !stat.scan_end && stat.is_alloc, "scan past the table")

endmodule
